### rtl/mgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgd_pkg
// Shared types and constants of the MAC grid divergence unit.
// ----------------------------------------------------------------------------
package mgd_pkg;

    localparam int SIZE_W      = 7;
    localparam int DIV_W       = 21;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_X_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] SIZE_Y_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] SIZE_Z_RST  = 7'd1;
    localparam logic              THREE_D_RST = 1'b0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIZE_X  = 2'd0,
        REG_SIZE_Y  = 2'd1,
        REG_SIZE_Z  = 2'd2,
        REG_THREE_D = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        NBR_ZERO = 2'd0,
        NBR_MEM  = 2'd1,
        NBR_CUR  = 2'd2
    } nbr_sel_t;

    typedef struct packed {
        logic     three_d;
        logic     border;
        logic     vol_end;
        nbr_sel_t nx_sel;
        nbr_sel_t ny_sel;
        logic     nz_cur;
    } stencil_ctrl_t;

    // clamp a size register to 1..mx
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int mx);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (int'(v) > mx) begin
            r = SIZE_W'(mx);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/mgd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgd_ram
// Generic synchronous RAM: one write port, RD_PORTS read ports, registered
// read data, read-before-write on address collision.
// ----------------------------------------------------------------------------
module mgd_ram #(
    parameter int WIDTH    = 8,
    parameter int DEPTH    = 16,
    parameter int RD_PORTS = 1
) (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire  [WIDTH-1:0]             wr_data,
    input  wire                          rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     rd_addr [RD_PORTS],
    output logic [WIDTH-1:0]             rd_data [RD_PORTS]
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int i = 0; i < RD_PORTS; i++) begin
                rd_data[i] <= mem[rd_addr[i]];
            end
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/mgd_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgd_stencil
// Divergence sum of one delayed cell from the store read data, and the
// result output register.
// ----------------------------------------------------------------------------
module mgd_stencil
    import mgd_pkg::*;
#(
    parameter int VEL_WIDTH = 18
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  stencil_ctrl_t              ctrl,
    input  wire  [3*VEL_WIDTH:0]       c_cell,
    input  wire  [VEL_WIDTH-1:0]       n_vx,
    input  wire  [VEL_WIDTH-1:0]       n_vy,
    input  wire  [VEL_WIDTH-1:0]       cur_vx,
    input  wire  [VEL_WIDTH-1:0]       cur_vy,
    input  wire  [VEL_WIDTH-1:0]       cur_vz,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [DIV_W-1:0]           out_div,
    output logic                       out_end
);

    localparam int ACC_W = (VEL_WIDTH + 3 > DIV_W) ? VEL_WIDTH + 3 : DIV_W;

    logic signed [VEL_WIDTH-1:0] c_vx;
    logic signed [VEL_WIDTH-1:0] c_vy;
    logic signed [VEL_WIDTH-1:0] c_vz;
    logic                        c_wet;
    logic signed [VEL_WIDTH-1:0] nx_vx;
    logic signed [VEL_WIDTH-1:0] ny_vy;
    logic signed [VEL_WIDTH-1:0] nz_vz;
    logic signed [ACC_W-1:0]     acc;
    logic [DIV_W-1:0]            div;

    logic                        valid_reg;
    logic                        valid_next;
    logic [DIV_W-1:0]            div_reg;
    logic                        end_reg;

    function automatic logic [VEL_WIDTH-1:0] pick(input nbr_sel_t sel,
                                                  input logic [VEL_WIDTH-1:0] mem_v,
                                                  input logic [VEL_WIDTH-1:0] cur_v);
        logic [VEL_WIDTH-1:0] r;
        case (sel)
            NBR_MEM: r = mem_v;
            NBR_CUR: r = cur_v;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        c_vx    = c_cell[VEL_WIDTH-1:0];
        c_vy    = c_cell[VEL_WIDTH +: VEL_WIDTH];
        c_vz    = ctrl.three_d ? c_cell[2*VEL_WIDTH +: VEL_WIDTH] : '0;
        c_wet   = c_cell[3*VEL_WIDTH];
        nx_vx   = pick(ctrl.nx_sel, n_vx, cur_vx);
        ny_vy   = pick(ctrl.ny_sel, n_vy, cur_vy);
        nz_vz   = (ctrl.three_d && ctrl.nz_cur) ? cur_vz : '0;
        acc     = ACC_W'(c_vx) - ACC_W'(nx_vx) + ACC_W'(c_vy) - ACC_W'(ny_vy)
                + ACC_W'(c_vz) - ACC_W'(nz_vz);
        div     = (ctrl.border || !c_wet) ? '0 : acc[DIV_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            div_reg <= div;
            end_reg <= ctrl.vol_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_end   = end_reg;

endmodule
`default_nettype wire

### rtl/mac_grid_divergence_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mac_grid_divergence_unit
// Velocity divergence on a staggered grid: a circular cell store delays the
// raster stream by one row (2D) or one plane (3D); each delayed cell leaves
// with its divergence, zero on border and dry cells.
// ----------------------------------------------------------------------------
// Result path: the read stage registers and the store read data, then the stencil output register.
// Throughput: one item per cycle; a cell writes the store, an emitting item
//   reads three store entries at its accepting edge; the input stalls only
//   while a full output is held by m_tready low.
// Reset: synchronous; clears pointers, fill count, raster position and the
//   result pipeline, sets the registers to 64 x 64 x 1, 2D; store not cleared.
// ----------------------------------------------------------------------------
module mac_grid_divergence_unit
    import mgd_pkg::*;
#(
    parameter int MAX_X     = 64,
    parameter int MAX_Y     = 64,
    parameter int MAX_Z     = 64,
    parameter int VEL_WIDTH = 18
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // vel_x, vel_y, vel_z, cell flag
    input  wire  [((3*VEL_WIDTH+1+7)/8)*8-1:0]     s_tdata,
    // drain
    input  wire                                    s_tuser,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // divergence
    output logic [M_TDATA_W-1:0]                   m_tdata,
    output logic                                   m_tlast,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]                 cfg_index,
    input  wire  [SIZE_W-1:0]                      cfg_data
);

    localparam int DEPTH  = MAX_X * MAX_Y;
    localparam int AW     = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CELL_W = 3 * VEL_WIDTH + 1;

    localparam logic [SIZE_W-1:0] SX_RST   = eff_size(SIZE_X_RST, MAX_X);
    localparam logic [SIZE_W-1:0] SY_RST   = eff_size(SIZE_Y_RST, MAX_Y);
    localparam logic [SIZE_W-1:0] SZ_RST   = eff_size(SIZE_Z_RST, MAX_Z);
    localparam int                PLANE_RI = int'(SX_RST) * int'(SY_RST);
    localparam logic [FILL_W-1:0] PLANE_RST = FILL_W'(PLANE_RI);
    localparam logic [FILL_W-1:0] DLEN_RST  = THREE_D_RST ? PLANE_RST : FILL_W'(SX_RST);

    // configuration
    logic [SIZE_W-1:0]   size_x_reg, size_x_next;
    logic [SIZE_W-1:0]   size_y_reg, size_y_next;
    logic [SIZE_W-1:0]   size_z_reg, size_z_next;
    logic                three_d_reg, three_d_next;
    logic [SIZE_W-1:0]   sx_reg, sx_next;
    logic [SIZE_W-1:0]   sy_reg, sy_next;
    logic [SIZE_W-1:0]   sz_reg, sz_next;
    logic [FILL_W-1:0]   plane_reg, plane_next;
    logic [FILL_W-1:0]   dlen_reg, dlen_next;
    logic [2*SIZE_W-1:0] plane_prod;
    logic                restart;

    // stream state
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [SIZE_W-1:0]   ox_reg, ox_next;
    logic [SIZE_W-1:0]   oy_reg, oy_next;
    logic [SIZE_W-1:0]   oz_reg, oz_next;

    logic                s_accept;
    logic                emit;
    logic                emit_go;
    logic                cell_wr;
    logic [AW-1:0]       rp_inc;
    logic [AW-1:0]       wp_inc;
    logic [AW:0]         far_sum;
    logic [AW-1:0]       rp_far;
    logic                bx, by, bz;
    stencil_ctrl_t       ctrl_next;

    // result stage
    logic                s1_valid_reg, s1_valid_next;
    stencil_ctrl_t       s1_ctrl_reg;
    logic [VEL_WIDTH-1:0] s1_vx_reg;
    logic [VEL_WIDTH-1:0] s1_vy_reg;
    logic [VEL_WIDTH-1:0] s1_vz_reg;
    logic                stc_ready;
    logic [DIV_W-1:0]    stc_div;

    logic [AW-1:0]       cell_rd_addr [2];
    logic [CELL_W-1:0]   cell_rd_data [2];
    logic [AW-1:0]       vy_rd_addr   [1];
    logic [VEL_WIDTH-1:0] vy_rd_data  [1];

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    // ---------------- configuration ----------------
    always_comb begin
        size_x_next  = size_x_reg;
        size_y_next  = size_y_reg;
        size_z_next  = size_z_reg;
        three_d_next = three_d_reg;
        restart      = 1'b0;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: begin
                    size_x_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_SIZE_Y: begin
                    size_y_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_SIZE_Z: begin
                    size_z_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_THREE_D: begin
                    three_d_next = cfg_data[0];
                    restart      = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
        sx_next    = eff_size(size_x_next, MAX_X);
        sy_next    = eff_size(size_y_next, MAX_Y);
        sz_next    = eff_size(size_z_next, MAX_Z);
        plane_prod = {{SIZE_W{1'b0}}, sx_next} * {{SIZE_W{1'b0}}, sy_next};
        plane_next = FILL_W'(plane_prod);
        dlen_next  = three_d_next ? plane_next : FILL_W'(sx_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg  <= SIZE_X_RST;
            size_y_reg  <= SIZE_Y_RST;
            size_z_reg  <= SIZE_Z_RST;
            three_d_reg <= THREE_D_RST;
            sx_reg      <= SX_RST;
            sy_reg      <= SY_RST;
            sz_reg      <= SZ_RST;
            plane_reg   <= PLANE_RST;
            dlen_reg    <= DLEN_RST;
        end else begin
            size_x_reg  <= size_x_next;
            size_y_reg  <= size_y_next;
            size_z_reg  <= size_z_next;
            three_d_reg <= three_d_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sz_reg      <= sz_next;
            plane_reg   <= plane_next;
            dlen_reg    <= dlen_next;
        end
    end

    // ---------------- store addressing ----------------
    always_comb begin
        rp_inc  = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        wp_inc  = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        far_sum = {1'b0, rp_reg} + (AW+1)'(sx_reg);
        rp_far  = (far_sum >= (AW+1)'(DEPTH)) ? AW'(far_sum - (AW+1)'(DEPTH))
                                              : far_sum[AW-1:0];
    end

    // ---------------- item control ----------------
    always_comb begin
        emit    = s_tuser ? (fill_reg != '0) : (fill_reg >= dlen_reg);
        emit_go = s_accept && emit;
        cell_wr = s_accept && !s_tuser;

        bx = (ox_reg == '0) || (({1'b0, ox_reg} + (SIZE_W+1)'(2)) > {1'b0, sx_reg});
        by = (oy_reg == '0) || (({1'b0, oy_reg} + (SIZE_W+1)'(2)) > {1'b0, sy_reg});
        bz = (oz_reg == '0) || (({1'b0, oz_reg} + (SIZE_W+1)'(2)) > {1'b0, sz_reg});

        ctrl_next.three_d = three_d_reg;
        ctrl_next.border  = bx || by || (three_d_reg && bz);
        ctrl_next.vol_end = (ox_reg == sx_reg - SIZE_W'(1)) &&
                            (oy_reg == sy_reg - SIZE_W'(1)) &&
                            (oz_reg == sz_reg - SIZE_W'(1));
        if (fill_reg > FILL_W'(1)) begin
            ctrl_next.nx_sel = NBR_MEM;
        end else if (fill_reg == FILL_W'(1) && !s_tuser) begin
            ctrl_next.nx_sel = NBR_CUR;
        end else begin
            ctrl_next.nx_sel = NBR_ZERO;
        end
        if (FILL_W'(sx_reg) < fill_reg) begin
            ctrl_next.ny_sel = NBR_MEM;
        end else if (FILL_W'(sx_reg) == fill_reg && !s_tuser) begin
            ctrl_next.ny_sel = NBR_CUR;
        end else begin
            ctrl_next.ny_sel = NBR_ZERO;
        end
        ctrl_next.nz_cur = three_d_reg && !s_tuser && (plane_reg == fill_reg);
    end

    always_comb begin
        fill_next = fill_reg;
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        oz_next   = oz_reg;
        if (restart) begin
            fill_next = '0;
            rp_next   = '0;
            wp_next   = '0;
            ox_next   = '0;
            oy_next   = '0;
            oz_next   = '0;
        end else if (s_accept) begin
            if (cell_wr) begin
                wp_next = wp_inc;
            end
            if (emit_go) begin
                rp_next = rp_inc;
                if (s_tuser) begin
                    fill_next = fill_reg - FILL_W'(1);
                end
                if (ox_reg == sx_reg - SIZE_W'(1)) begin
                    ox_next = '0;
                    if (oy_reg == sy_reg - SIZE_W'(1)) begin
                        oy_next = '0;
                        oz_next = (oz_reg == sz_reg - SIZE_W'(1)) ? '0 : oz_reg + SIZE_W'(1);
                    end else begin
                        oy_next = oy_reg + SIZE_W'(1);
                    end
                end else begin
                    ox_next = ox_reg + SIZE_W'(1);
                end
            end else if (cell_wr) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            rp_reg   <= '0;
            wp_reg   <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            oz_reg   <= oz_next;
        end
    end

    // ---------------- cell store ----------------
    assign cell_rd_addr[0] = rp_reg;
    assign cell_rd_addr[1] = rp_inc;
    assign vy_rd_addr[0]   = rp_far;

    mgd_ram #(
        .WIDTH    (CELL_W),
        .DEPTH    (DEPTH),
        .RD_PORTS (2)
    ) u_cell_mem (
        .aclk    (aclk),
        .wr_en   (cell_wr),
        .wr_addr (wp_reg),
        .wr_data (s_tdata[CELL_W-1:0]),
        .rd_en   (emit_go),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    mgd_ram #(
        .WIDTH    (VEL_WIDTH),
        .DEPTH    (DEPTH),
        .RD_PORTS (1)
    ) u_vy_mem (
        .aclk    (aclk),
        .wr_en   (cell_wr),
        .wr_addr (wp_reg),
        .wr_data (s_tdata[VEL_WIDTH +: VEL_WIDTH]),
        .rd_en   (emit_go),
        .rd_addr (vy_rd_addr),
        .rd_data (vy_rd_data)
    );

    // ---------------- read stage ----------------
    assign s_tready = !s1_valid_reg || stc_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (emit_go) begin
            s1_valid_next = 1'b1;
        end else if (stc_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            s1_ctrl_reg <= ctrl_next;
            s1_vx_reg   <= s_tdata[VEL_WIDTH-1:0];
            s1_vy_reg   <= s_tdata[VEL_WIDTH +: VEL_WIDTH];
            s1_vz_reg   <= s_tdata[2*VEL_WIDTH +: VEL_WIDTH];
        end
    end

    mgd_stencil #(
        .VEL_WIDTH (VEL_WIDTH)
    ) u_stencil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (stc_ready),
        .ctrl      (s1_ctrl_reg),
        .c_cell    (cell_rd_data[0]),
        .n_vx      (cell_rd_data[1][VEL_WIDTH-1:0]),
        .n_vy      (vy_rd_data[0]),
        .cur_vx    (s1_vx_reg),
        .cur_vy    (s1_vy_reg),
        .cur_vz    (s1_vz_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_div   (stc_div),
        .out_end   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - DIV_W){1'b0}}, stc_div};

endmodule
`default_nettype wire

### rtl/mgd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgd_checker
// Port-level checks of the MAC grid divergence unit, bound to the top level.
// ----------------------------------------------------------------------------
module mgd_checker
    import mgd_pkg::*;
(
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [M_TDATA_W-1:0]   m_tdata,
    input wire                   m_tlast
);

    // reset empties the result pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // a new result follows an input transaction through the read stage and the output register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transaction");

endmodule

bind mac_grid_divergence_unit mgd_checker u_mgd_checker (.*);
`default_nettype wire
